// File: hw/rtl/brush_coverage_mask_assert.svh
// Assertion macros shared by the brush coverage mask checkers.
// Depends on nothing; included by the checker module only.
`ifndef BRUSH_COVERAGE_MASK_ASSERT_SVH
`define BRUSH_COVERAGE_MASK_ASSERT_SVH

// Same-cycle implication, skipped while reset is held.
`define BCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("brush coverage mask check failed");

// Next-cycle implication, skipped while reset is held.
`define BCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("brush coverage mask check failed");

// Next-cycle implication that also watches the reset itself.
`define BCM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("brush coverage mask check failed");

`endif

// File: hw/rtl/bcm_pkg.sv
// Shared types, constants and helpers of the brush coverage mask.
// Depends on nothing; used by brush_coverage_mask, bcm_sqrt_pipe and bcm_div_pipe.
package bcm_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_SHAPE   = 2'd0;
    localparam logic [1:0] REG_SIZE    = 2'd1;
    localparam logic [1:0] REG_FALLOFF = 2'd2;

    // Brush shape codes; codes above noise behave as a circle.
    localparam logic [2:0] SHAPE_CIRCLE  = 3'd0;
    localparam logic [2:0] SHAPE_SQUARE  = 3'd1;
    localparam logic [2:0] SHAPE_DIAMOND = 3'd2;
    localparam logic [2:0] SHAPE_RING    = 3'd3;
    localparam logic [2:0] SHAPE_NOISE   = 3'd4;

    // Falloff mode codes.
    localparam logic [1:0] FALL_HARD   = 2'd0;
    localparam logic [1:0] FALL_LINEAR = 2'd1;
    localparam logic [1:0] FALL_SMOOTH = 2'd2;
    localparam logic [1:0] FALL_DITHER = 2'd3;

    // Coordinate hash multipliers.
    localparam logic [31:0] HASH_MUL_X   = 32'd73856093;
    localparam logic [31:0] HASH_MUL_Y   = 32'd19349663;
    localparam logic [31:0] HASH_MUL_MIX = 32'h5BD1E995;

    // Q1.16 unity.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Square root: radicand is (ax^2 + ay^2) followed by 32 zero bits.
    localparam int RAD_W          = 14;
    localparam int ROOT_W         = 23;
    localparam int REM_W          = 24;
    localparam int SQRT_STEPS     = 23;
    localparam int SQRT_PER_STAGE = 3;
    localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

    // Divider: 26-bit dividend over a 7-bit divisor.
    localparam int DIVN_W        = 26;
    localparam int DIVR_W        = 7;
    localparam int DIV_STEPS     = 26;
    localparam int DIV_PER_STAGE = 3;
    localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic [6:0]  ax;
        logic [6:0]  ay;
        logic [31:0] hash;
        logic [3:0]  dith_idx;
    } sqrt_side_t;

    typedef struct packed {
        logic [DIVR_W-1:0] rem;
        logic [DIVN_W-1:0] numq;
    } div_state_t;

    typedef struct packed {
        logic       in_reach;
        logic [7:0] gain;
        logic [3:0] dith_idx;
    } div_side_t;

    // 4x4 ordered dither threshold, index is {y[1:0], x[1:0]}.
    function automatic logic [3:0] bayer4(input logic [3:0] idx);
        logic [3:0] k;
        case (idx)
            4'd0:  k = 4'd0;
            4'd1:  k = 4'd8;
            4'd2:  k = 4'd2;
            4'd3:  k = 4'd10;
            4'd4:  k = 4'd12;
            4'd5:  k = 4'd4;
            4'd6:  k = 4'd14;
            4'd7:  k = 4'd6;
            4'd8:  k = 4'd3;
            4'd9:  k = 4'd11;
            4'd10: k = 4'd1;
            4'd11: k = 4'd9;
            4'd12: k = 4'd15;
            4'd13: k = 4'd7;
            4'd14: k = 4'd13;
            default: k = 4'd5;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/brush_coverage_mask.sv
// Brush coverage mask: one coverage byte per brush cell, fully pipelined.
// Depends on bcm_pkg, bcm_sqrt_pipe and bcm_div_pipe.
//
// The block takes one item per clock while m_ready does not hold it back and
// returns one coverage byte per item, in order. The pipeline is made of the
// Euclidean distance square root (8 stages of 3 root bits) and the share
// divider (9 stages of 3 quotient bits), plus seven stages for input setup,
// distance selection, falloff shaping, noise scaling and the output register.
// The whole pipeline holds while a finished item waits on m_ready, so
// s_ready is high whenever the output register is empty or being taken.
// Configuration registers may be written only while no item is in flight.
module brush_coverage_mask #(
    parameter int MAX_SIZE = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_unit_x,
    input  logic signed [31:0] s_unit_y,
    input  logic signed [6:0]  s_offset_x,
    input  logic signed [6:0]  s_offset_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_coverage
);

    localparam int         SIZE_LIM = (MAX_SIZE > 127) ? 127 : MAX_SIZE;
    localparam logic [6:0] SIZE_CAP = 7'(SIZE_LIM);

    // Magnitude of a 7-bit two's complement offset; -64 gives 64.
    function automatic logic [6:0] mag7(input logic [6:0] v);
        logic [7:0] neg;
        neg = 8'd128 - {1'b0, v};
        return v[6] ? neg[6:0] : v;
    endfunction

    // Configuration registers.
    logic [2:0] shape_reg;
    logic [6:0] size_reg;
    logic [1:0] falloff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg   <= bcm_pkg::SHAPE_CIRCLE;
            size_reg    <= 7'd3;
            falloff_reg <= bcm_pkg::FALL_LINEAR;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bcm_pkg::REG_SHAPE:   shape_reg   <= cfg_wr_data[2:0];
                bcm_pkg::REG_SIZE:    size_reg    <= cfg_wr_data;
                bcm_pkg::REG_FALLOFF: falloff_reg <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    // Reach and divisor follow configuration, which users must keep steady while items run (unchecked).
    logic [6:0]  size_eff;
    logic [23:0] reach;
    logic [6:0]  divisor;
    logic        is_ring;
    logic        is_noise;

    assign size_eff = (size_reg > SIZE_CAP) ? SIZE_CAP : size_reg;
    assign reach    = {1'b0, size_eff, 16'b0};
    assign is_ring  = (shape_reg == bcm_pkg::SHAPE_RING);
    assign is_noise = (shape_reg == bcm_pkg::SHAPE_NOISE);

    always_comb begin
        if (is_ring) begin
            divisor = (size_eff < 7'd4) ? 7'd4 : size_eff;
        end else begin
            divisor = (size_eff == 7'd1) ? 7'd2 : size_eff;
        end
    end

    // The pipeline advances whenever the output register can move.
    logic m_valid_reg;
    logic en;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Input stage: offset magnitudes, squared radius and first hash products.
    logic        s0_valid_reg;
    logic [6:0]  s0_ax_reg;
    logic [6:0]  s0_ay_reg;
    logic [13:0] s0_rad_reg;
    logic [31:0] s0_hash_reg;
    logic [3:0]  s0_idx_reg;

    logic [6:0]  ax_next;
    logic [6:0]  ay_next;
    logic [13:0] rad_next;
    logic [31:0] hash_next;

    always_comb begin
        logic [31:0] px;
        logic [31:0] py;
        ax_next   = mag7(s_offset_x);
        ay_next   = mag7(s_offset_y);
        rad_next  = ({7'b0, ax_next} * {7'b0, ax_next}) + ({7'b0, ay_next} * {7'b0, ay_next});
        px        = s_unit_x * bcm_pkg::HASH_MUL_X;
        py        = s_unit_y * bcm_pkg::HASH_MUL_Y;
        hash_next = px ^ py;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_ax_reg   <= ax_next;
            s0_ay_reg   <= ay_next;
            s0_rad_reg  <= rad_next;
            s0_hash_reg <= hash_next;
            s0_idx_reg  <= {s_unit_y[1:0], s_unit_x[1:0]};
        end
    end

    // Euclidean distance square root.
    bcm_pkg::sqrt_state_t sq_in_state;
    bcm_pkg::sqrt_side_t  sq_in_side;
    logic                 sq_valid;
    bcm_pkg::sqrt_state_t sq_state;
    bcm_pkg::sqrt_side_t  sq_side;

    assign sq_in_state = '{rad: s0_rad_reg, rem: '0, root: '0};
    assign sq_in_side  = '{ax: s0_ax_reg, ay: s0_ay_reg, hash: s0_hash_reg,
                           dith_idx: s0_idx_reg};

    bcm_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_state  (sq_in_state),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .out_state (sq_state),
        .out_side  (sq_side)
    );

    // Distance stage: pick the metric, test reach and form the dividend.
    logic        p_valid_reg;
    logic        p_reach_reg;
    logic [25:0] p_dividend_reg;
    logic [31:0] p_mix_reg;
    logic [3:0]  p_idx_reg;

    logic        reach_next;
    logic [25:0] dividend_next;
    logic [31:0] mix_next;

    always_comb begin
        logic [6:0]  cheb;
        logic [7:0]  manh;
        logic [23:0] dist_q;
        logic [23:0] band;
        logic [23:0] mid;
        logic [23:0] dev;
        logic [23:0] gap;
        logic [31:0] s1;
        cheb = (sq_side.ax > sq_side.ay) ? sq_side.ax : sq_side.ay;
        manh = {1'b0, sq_side.ax} + {1'b0, sq_side.ay};
        case (shape_reg)
            bcm_pkg::SHAPE_SQUARE:  dist_q = {1'b0, cheb, 16'b0};
            bcm_pkg::SHAPE_DIAMOND: dist_q = {manh, 16'b0};
            default:                dist_q = {1'b0, sq_state.root};
        endcase
        reach_next = (dist_q < reach);
        band = (size_eff >= 7'd2) ? {2'b0, size_eff, 15'b0} : 24'h010000;
        mid  = reach - {1'b0, band[23:1]};
        dev  = (dist_q >= mid) ? (dist_q - mid) : (mid - dist_q);
        gap  = reach - dist_q;
        dividend_next = is_ring ? {dev, 2'b00} : {1'b0, gap, 1'b0};
        s1       = sq_side.hash ^ (sq_side.hash >> 13);
        mix_next = s1 * bcm_pkg::HASH_MUL_MIX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reach_reg    <= reach_next;
            p_dividend_reg <= dividend_next;
            p_mix_reg      <= mix_next;
            p_idx_reg      <= sq_side.dith_idx;
        end
    end

    // Share divider.
    logic [31:0]         mix_fold;
    bcm_pkg::div_state_t dv_in_state;
    bcm_pkg::div_side_t  dv_in_side;
    logic                dv_valid;
    bcm_pkg::div_state_t dv_state;
    bcm_pkg::div_side_t  dv_side;

    assign mix_fold    = p_mix_reg ^ (p_mix_reg >> 15);
    assign dv_in_state = '{rem: '0, numq: p_dividend_reg};
    assign dv_in_side  = '{in_reach: p_reach_reg, gain: mix_fold[7:0], dith_idx: p_idx_reg};

    bcm_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .divisor   (divisor),
        .in_valid  (p_valid_reg),
        .in_state  (dv_in_state),
        .in_side   (dv_in_side),
        .out_valid (dv_valid),
        .out_state (dv_state),
        .out_side  (dv_side)
    );

    // Clamp the quotient to a share in [0, 1] and square it for smoothstep.
    logic        q1_valid_reg;
    logic [16:0] q1_share_reg;
    logic [33:0] q1_sq_reg;
    logic [7:0]  q1_gain_reg;
    logic [3:0]  q1_idx_reg;

    logic [16:0] share_next;

    always_comb begin
        logic [25:0] q;
        q = dv_state.numq;
        if (!dv_side.in_reach) begin
            share_next = '0;
        end else if (is_ring) begin
            share_next = (q >= 26'h10000) ? 17'd0 : (bcm_pkg::ONE_Q16 - q[16:0]);
        end else begin
            share_next = (q > 26'h10000) ? bcm_pkg::ONE_Q16 : q[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_valid_reg <= 1'b0;
        end else if (en) begin
            q1_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_share_reg <= share_next;
            q1_sq_reg    <= share_next * share_next;
            q1_gain_reg  <= dv_side.gain;
            q1_idx_reg   <= dv_side.dith_idx;
        end
    end

    // Smoothstep product and the single-compare falloff modes.
    logic        q2_valid_reg;
    logic [35:0] q2_prod_reg;
    logic [16:0] q2_other_reg;
    logic [7:0]  q2_gain_reg;

    logic [35:0] prod_next;
    logic [16:0] other_next;

    always_comb begin
        logic [16:0] s2;
        logic [18:0] t;
        s2 = q1_sq_reg[32:16];
        t  = 19'h30000 - {1'b0, q1_share_reg, 1'b0};
        prod_next = s2 * t;
        case (falloff_reg)
            bcm_pkg::FALL_HARD:
                other_next = (q1_share_reg != 17'd0) ? bcm_pkg::ONE_Q16 : 17'd0;
            bcm_pkg::FALL_DITHER:
                other_next = (q1_share_reg > {1'b0, bcm_pkg::bayer4(q1_idx_reg), 12'b0})
                             ? bcm_pkg::ONE_Q16 : 17'd0;
            default:
                other_next = q1_share_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q2_valid_reg <= 1'b0;
        end else if (en) begin
            q2_valid_reg <= q1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q2_prod_reg  <= prod_next;
            q2_other_reg <= other_next;
            q2_gain_reg  <= q1_gain_reg;
        end
    end

    // Select the shaped share and scale it by the hash byte.
    logic        q3_valid_reg;
    logic [16:0] q3_share_reg;
    logic [24:0] q3_np_reg;

    logic [16:0] shaped;

    assign shaped = (falloff_reg == bcm_pkg::FALL_SMOOTH) ? q2_prod_reg[32:16] : q2_other_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q3_valid_reg <= 1'b0;
        end else if (en) begin
            q3_valid_reg <= q2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q3_share_reg <= shaped;
            q3_np_reg    <= shaped * q2_gain_reg;
        end
    end

    // Divide by 255: estimate through the reciprocal 257 / 2^16.
    logic        q4_valid_reg;
    logic [16:0] q4_share_reg;
    logic [24:0] q4_np_reg;
    logic [17:0] q4_est_reg;

    logic [33:0] recip_prod;

    assign recip_prod = {1'b0, q3_np_reg, 8'b0} + {9'b0, q3_np_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q4_valid_reg <= 1'b0;
        end else if (en) begin
            q4_valid_reg <= q3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q4_share_reg <= q3_share_reg;
            q4_np_reg    <= q3_np_reg;
            q4_est_reg   <= recip_prod[33:16];
        end
    end

    // Correct the estimate by one, then scale the share to a byte.
    logic [7:0] m_cov_reg;
    logic [7:0] cov_next;

    always_comb begin
        logic [25:0] est255;
        logic [25:0] rem;
        logic [17:0] quo;
        logic [16:0] final_share;
        logic [24:0] scaled;
        est255 = {q4_est_reg, 8'b0} - {8'b0, q4_est_reg};
        rem    = {1'b0, q4_np_reg} - est255;
        quo    = (rem >= 26'd255) ? (q4_est_reg + 18'd1) : q4_est_reg;
        final_share = is_noise ? quo[16:0] : q4_share_reg;
        scaled   = {final_share, 8'b0} - {8'b0, final_share};
        cov_next = scaled[23:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_cov_reg <= cov_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_coverage = m_cov_reg;

endmodule

// File: hw/rtl/bcm_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, SQRT_PER_STAGE steps per stage.
// Depends on bcm_pkg for the state and sideband types.
module bcm_sqrt_pipe (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  bcm_pkg::sqrt_state_t in_state,
    input  bcm_pkg::sqrt_side_t  in_side,
    output logic                 out_valid,
    output bcm_pkg::sqrt_state_t out_state,
    output bcm_pkg::sqrt_side_t  out_side
);

    localparam int NST = bcm_pkg::SQRT_STAGES;
    localparam int PER = bcm_pkg::SQRT_PER_STAGE;

    logic [NST-1:0]       valid_reg;
    logic [NST-1:0]       stage_valid_in;
    bcm_pkg::sqrt_state_t stage_state_in [NST];
    bcm_pkg::sqrt_side_t  stage_side_in  [NST];
    bcm_pkg::sqrt_state_t state_next     [NST];
    bcm_pkg::sqrt_state_t state_reg      [NST];
    bcm_pkg::sqrt_side_t  side_reg       [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        // Each stage takes its item from the stage before it.
        if (g == 0) begin : g_first
            assign stage_valid_in[g] = in_valid;
            assign stage_state_in[g] = in_state;
            assign stage_side_in[g]  = in_side;
        end else begin : g_rest
            assign stage_valid_in[g] = valid_reg[g-1];
            assign stage_state_in[g] = state_reg[g-1];
            assign stage_side_in[g]  = side_reg[g-1];
        end

        // Bring down two radicand bits per step and try the next root bit.
        always_comb begin
            bcm_pkg::sqrt_state_t         st;
            logic [bcm_pkg::REM_W+1:0]    r2;
            logic [bcm_pkg::REM_W+1:0]    trial;
            logic [bcm_pkg::REM_W+1:0]    diff;
            logic                         ge;
            st = stage_state_in[g];
            for (int k = 0; k < PER; k++) begin
                if (g * PER + k < bcm_pkg::SQRT_STEPS) begin
                    r2    = {st.rem, st.rad[bcm_pkg::RAD_W-1 -: 2]};
                    trial = {1'b0, st.root, 2'b01};
                    diff  = r2 - trial;
                    ge    = (r2 >= trial);
                    st.rem  = ge ? diff[bcm_pkg::REM_W-1:0] : r2[bcm_pkg::REM_W-1:0];
                    st.root = {st.root[bcm_pkg::ROOT_W-2:0], ge};
                    st.rad  = {st.rad[bcm_pkg::RAD_W-3:0], 2'b00};
                end
            end
            state_next[g] = st;
        end

        // Valid bits travel with the data.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= stage_valid_in[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                state_reg[g] <= state_next[g];
                side_reg[g]  <= stage_side_in[g];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_state = state_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

// File: hw/rtl/bcm_div_pipe.sv
// Pipelined restoring divider, DIV_PER_STAGE quotient bits per stage.
// Depends on bcm_pkg for the state and sideband types.
module bcm_div_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [bcm_pkg::DIVR_W-1:0]    divisor,
    input  logic                          in_valid,
    input  bcm_pkg::div_state_t           in_state,
    input  bcm_pkg::div_side_t            in_side,
    output logic                          out_valid,
    output bcm_pkg::div_state_t           out_state,
    output bcm_pkg::div_side_t            out_side
);

    localparam int NST = bcm_pkg::DIV_STAGES;
    localparam int PER = bcm_pkg::DIV_PER_STAGE;

    logic [NST-1:0]      valid_reg;
    logic [NST-1:0]      stage_valid_in;
    bcm_pkg::div_state_t stage_state_in [NST];
    bcm_pkg::div_side_t  stage_side_in  [NST];
    bcm_pkg::div_state_t state_next     [NST];
    bcm_pkg::div_state_t state_reg      [NST];
    bcm_pkg::div_side_t  side_reg       [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign stage_valid_in[g] = in_valid;
            assign stage_state_in[g] = in_state;
            assign stage_side_in[g]  = in_side;
        end else begin : g_rest
            assign stage_valid_in[g] = valid_reg[g-1];
            assign stage_state_in[g] = state_reg[g-1];
            assign stage_side_in[g]  = side_reg[g-1];
        end

        // Dividend bits shift out at the top while quotient bits shift in below.
        always_comb begin
            bcm_pkg::div_state_t        st;
            logic [bcm_pkg::DIVR_W:0]   r2;
            logic [bcm_pkg::DIVR_W:0]   diff;
            logic                       ge;
            st = stage_state_in[g];
            for (int k = 0; k < PER; k++) begin
                if (g * PER + k < bcm_pkg::DIV_STEPS) begin
                    r2      = {st.rem, st.numq[bcm_pkg::DIVN_W-1]};
                    diff    = r2 - {1'b0, divisor};
                    ge      = (r2 >= {1'b0, divisor});
                    st.rem  = ge ? diff[bcm_pkg::DIVR_W-1:0] : r2[bcm_pkg::DIVR_W-1:0];
                    st.numq = {st.numq[bcm_pkg::DIVN_W-2:0], ge};
                end
            end
            state_next[g] = st;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= stage_valid_in[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                state_reg[g] <= state_next[g];
                side_reg[g]  <= stage_side_in[g];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_state = state_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

// File: hw/rtl/brush_coverage_mask_checker.sv
// Port-level checks of the brush coverage mask and their bind to the top level.
// Depends on brush_coverage_mask_assert.svh and brush_coverage_mask.
`include "brush_coverage_mask_assert.svh"

module brush_coverage_mask_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_coverage
);

    // Reset empties the output register.
    `BCM_ASSERT_NXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_valid)

    // An empty output register never holds back the input side.
    `BCM_ASSERT_IMP(a_empty_ready, aclk, aresetn, !m_valid, s_ready)

    // A taken result frees the pipeline for a new item in the same cycle.
    `BCM_ASSERT_IMP(a_taken_ready, aclk, aresetn, m_ready, s_ready)

    // A stalled result stays put.
    `BCM_ASSERT_NXT(a_hold_result, aclk, aresetn, m_valid && !m_ready,
                    m_valid && $stable(m_coverage))

endmodule

bind brush_coverage_mask brush_coverage_mask_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_coverage (m_coverage)
);

// File: test/brush_coverage_mask_tb.sv
// Self-checking testbench for the brush coverage mask block.
// Depends on bcm_pkg and brush_coverage_mask; needs no files or arguments.
`timescale 1ns / 1ps

module brush_coverage_mask_tb;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 96;

    typedef struct {
        logic [2:0]  shape;
        logic [6:0]  size;
        logic [1:0]  mode;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [6:0]  ox;
        logic [6:0]  oy;
        int          cov;    // typed coverage, or -1 to use the predictor
    } cell_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_unit_x;
    logic signed [31:0] s_unit_y;
    logic signed [6:0]  s_offset_x;
    logic signed [6:0]  s_offset_y;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_coverage;

    // Shadow copy of the block's configuration.
    logic [2:0] cur_shape;
    logic [6:0] cur_size;
    logic [1:0] cur_mode;

    logic [7:0] coverage_due[$];
    int         cycles;
    int         errors;
    int         cells_sent;
    int         cells_seen;
    int         idle_pct;
    int         stall_pct;

    brush_coverage_mask uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_unit_x   (s_unit_x),
        .s_unit_y   (s_unit_y),
        .s_offset_x (s_offset_x),
        .s_offset_y (s_offset_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_coverage (m_coverage)
    );

    // Clock with an 8 ns period.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Magnitude of a 7-bit signed offset; -64 gives 64.
    function automatic longint unsigned offset_mag(input logic [6:0] v);
        return v[6] ? 64'(8'd128 - {1'b0, v}) : 64'(v);
    endfunction

    // Truncated integer square root, one result bit per step.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Noise gain byte taken from the world coordinate.
    function automatic logic [7:0] noise_gain(input logic [31:0] ux, input logic [31:0] uy);
        logic [31:0] h;
        h = (ux * bcm_pkg::HASH_MUL_X) ^ (uy * bcm_pkg::HASH_MUL_Y);
        h ^= h >> 13;
        h = h * bcm_pkg::HASH_MUL_MIX;
        h ^= h >> 15;
        return h[7:0];
    endfunction

    // Coverage byte of one cell under the current configuration.
    function automatic logic [7:0] cell_coverage(input logic [31:0] ux, input logic [31:0] uy,
                                                 input logic [6:0] ox, input logic [6:0] oy);
        longint unsigned ax, ay, reach, span, share, band, mid, half, dev, drop, s2, thr;
        ax = offset_mag(ox);
        ay = offset_mag(oy);
        reach = (cur_size > 64 ? 64'd64 : 64'(cur_size)) << 16;
        if (cur_shape == bcm_pkg::SHAPE_SQUARE) span = (ax > ay ? ax : ay) << 16;
        else if (cur_shape == bcm_pkg::SHAPE_DIAMOND) span = (ax + ay) << 16;
        else span = int_sqrt((ax * ax + ay * ay) << 32);
        if (span >= reach) return 8'd0;

        // Ring peaks in the middle of the outer band; other shapes ramp from the edge.
        if (cur_shape == bcm_pkg::SHAPE_RING) begin
            band = reach >> 1;
            if (band < 65536) band = 65536;
            mid = reach - (band >> 1);
            half = band >> 1;
            if (half < 65536) half = 65536;
            dev = span >= mid ? span - mid : mid - span;
            drop = (dev << 16) / half;
            share = drop >= 65536 ? 0 : 65536 - drop;
        end else begin
            half = reach >> 1;
            if (half < 65536) half = 65536;
            share = ((reach - span) << 16) / half;
        end
        if (share > 65536) share = 65536;

        case (cur_mode)
            bcm_pkg::FALL_HARD: share = share > 0 ? 65536 : 0;
            bcm_pkg::FALL_SMOOTH: begin
                s2 = (share * share) >> 16;
                share = (s2 * (3 * 65536 - 2 * share)) >> 16;
            end
            bcm_pkg::FALL_DITHER: begin
                thr = 64'(bcm_pkg::bayer4({uy[1:0], ux[1:0]})) << 12;
                share = share > thr ? 65536 : 0;
            end
            default: ;
        endcase

        if (cur_shape == bcm_pkg::SHAPE_NOISE) share = (share * noise_gain(ux, uy)) / 255;
        return 8'((share * 255) >> 16);
    endfunction

    // Result checker: every accepted coverage byte against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            cells_seen <= cells_seen + 1;
            if (coverage_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %0d", $time, m_coverage);
            end else begin
                if (m_coverage !== coverage_due[0]) begin
                    errors++;
                    $display("%0t: coverage mismatch, expected %0d, actual %0d",
                             $time, coverage_due[0], m_coverage);
                end
                void'(coverage_due.pop_front());
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Waits for every expected item, then lets the pipeline settle.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (coverage_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One register write; the enable drops again before the next write.
    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bcm_pkg::REG_SHAPE:   cur_shape = data[2:0];
            bcm_pkg::REG_SIZE:    cur_size  = data;
            bcm_pkg::REG_FALLOFF: cur_mode  = data[1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_brush(input logic [2:0] shape, input logic [6:0] size,
                             input logic [1:0] mode);
        drain_block();
        write_reg(bcm_pkg::REG_SHAPE, {4'd0, shape});
        write_reg(bcm_pkg::REG_SIZE, size);
        write_reg(bcm_pkg::REG_FALLOFF, {5'd0, mode});
    endtask

    // Offers one item, waits for the handshake, then maybe idles.
    task automatic send_cell(input logic [31:0] ux, input logic [31:0] uy,
                             input logic [6:0] ox, input logic [6:0] oy, input int typed);
        logic [7:0] want;
        s_valid    <= 1'b1;
        s_unit_x   <= ux;
        s_unit_y   <= uy;
        s_offset_x <= ox;
        s_offset_y <= oy;
        do @(posedge aclk); while (!s_ready);
        want = cell_coverage(ux, uy, ox, oy);
        if (typed >= 0 && want != 8'(typed)) begin
            errors++;
            $display("%0t: predictor disagrees with table, expected %0d, actual %0d",
                     $time, typed, want);
        end
        coverage_due.push_back(typed >= 0 ? 8'(typed) : want);
        cells_sent++;
        @(negedge aclk);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
    endtask

    // Random offset, mostly inside the current reach.
    function automatic logic [6:0] pick_offset();
        int r;
        if ($urandom_range(3) == 0) return 7'($urandom);
        r = cur_size > 64 ? 64 : int'(cur_size);
        return 7'($urandom_range(2 * r, 0) - r);
    endfunction

    function automatic logic [31:0] pick_unit();
        return $urandom_range(1) ? $urandom : 32'($urandom_range(15));
    endfunction

    cell_row_t table_rows[] = '{
        '{bcm_pkg::SHAPE_CIRCLE, 7'd3, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd0, 7'd0, 255},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd3, bcm_pkg::FALL_LINEAR, 32'd5, 32'd9, 7'd3, 7'd0, 0},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd3, bcm_pkg::FALL_LINEAR, 32'd1, 32'd2, 7'h40, 7'h40, 0},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd3, bcm_pkg::FALL_LINEAR, 32'h80000000, 32'h7FFFFFFF,
          7'd1, 7'h7F, -1},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd64, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd63, 7'd63, 0},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd64, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd40, 7'h41, -1},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd0, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd0, 7'd0, 0},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd127, bcm_pkg::FALL_LINEAR, 32'd3, 32'd3, 7'd0, 7'd0, 255},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd127, bcm_pkg::FALL_LINEAR, 32'd3, 32'd3, 7'h40, 7'd0, 0},
        '{bcm_pkg::SHAPE_SQUARE, 7'd8, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd5, 7'h7E, -1},
        '{bcm_pkg::SHAPE_DIAMOND, 7'd8, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd3, 7'h7D, -1},
        '{bcm_pkg::SHAPE_RING, 7'd8, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd6, 7'd0, -1},
        '{bcm_pkg::SHAPE_RING, 7'd1, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd0, 7'd0, -1},
        '{bcm_pkg::SHAPE_NOISE, 7'd8, bcm_pkg::FALL_LINEAR, 32'hFFFFFFFF, 32'h80000000,
          7'd1, 7'd2, -1},
        '{bcm_pkg::SHAPE_NOISE, 7'd8, bcm_pkg::FALL_HARD, 32'h12345678, 32'h9ABCDEF0,
          7'd0, 7'd0, -1},
        '{3'd7, 7'd8, bcm_pkg::FALL_LINEAR, 32'd0, 32'd0, 7'd2, 7'd2, -1},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd8, bcm_pkg::FALL_HARD, 32'd0, 32'd0, 7'd7, 7'd0, 255},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd8, bcm_pkg::FALL_SMOOTH, 32'd0, 32'd0, 7'd5, 7'd1, -1},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd8, bcm_pkg::FALL_DITHER, 32'd3, 32'd3, 7'd6, 7'd0, -1},
        '{bcm_pkg::SHAPE_CIRCLE, 7'd8, bcm_pkg::FALL_DITHER, 32'd0, 32'd0, 7'd0, 7'd0, 255}
    };

    initial begin
        int dir_i;
        int phase;
        int setting;
        int k;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = bcm_pkg::REG_SHAPE;
        cfg_wr_data = 7'd0;
        s_valid     = 1'b0;
        s_unit_x    = 32'sd0;
        s_unit_y    = 32'sd0;
        s_offset_x  = 7'sd0;
        s_offset_y  = 7'sd0;
        m_ready     = 1'b1;
        errors      = 0;
        cells_sent  = 0;
        cells_seen  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        cur_shape   = bcm_pkg::SHAPE_CIRCLE;
        cur_size    = 7'd3;
        cur_mode    = bcm_pkg::FALL_LINEAR;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table; the first rows run on the reset configuration.
        for (dir_i = 0; dir_i < table_rows.size(); dir_i++) begin
            if (table_rows[dir_i].shape != cur_shape || table_rows[dir_i].size != cur_size ||
                table_rows[dir_i].mode != cur_mode) begin
                set_brush(table_rows[dir_i].shape, table_rows[dir_i].size,
                          table_rows[dir_i].mode);
            end
            send_cell(table_rows[dir_i].ux, table_rows[dir_i].uy, table_rows[dir_i].ox,
                      table_rows[dir_i].oy, table_rows[dir_i].cov);
        end

        // Random part in four pacing phases, several brush settings each.
        for (phase = 0; phase < 4; phase++) begin
            for (setting = 0; setting < 4; setting++) begin
                drain_block();
                case (phase)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 56; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 56; end
                    default: begin idle_pct = 27; stall_pct = 27; end
                endcase
                case (setting)
                    0: set_brush(3'($urandom_range(7)), 7'd1, 2'($urandom_range(3)));
                    1: set_brush(3'($urandom_range(7)), 7'd127, 2'($urandom_range(3)));
                    default: set_brush(3'($urandom_range(7)), 7'($urandom_range(127)),
                                       2'($urandom_range(3)));
                endcase
                for (k = 0; k < RAND_ITEMS; k++) begin
                    // Some stretches run without any idling.
                    send_cell(pick_unit(), pick_unit(), pick_offset(), pick_offset(), -1);
                end
            end
        end

        drain_block();
        $display("Sent %0d cells, checked %0d coverage bytes over all shapes,", cells_sent,
                 cells_seen);
        $display("falloff modes, size extremes and four idle/stall mixes.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
